>>> rtl/sqch_pkg.sv
// Shared types, constants and helper functions for the square channel with sweep.
// Used by square_channel_with_sweep and its testbench; depends on nothing else.
package sqch_pkg;

   localparam int unsigned PERIOD_W    = 11;
   localparam int unsigned COUNTDOWN_W = 14;
   localparam int unsigned LENGTH_W    = 7;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [3:0]          SWEEP_RELOAD = 4'd8;
   localparam logic [LENGTH_W-1:0] LENGTH_FULL  = 7'd64;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_FRAME   = 2'd1,
      OP_TRIGGER = 2'd2,
      OP_LENGTH  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_SWEEP    = 3'd0,
      CSR_DUTY     = 3'd1,
      CSR_ENVELOPE = 3'd2,
      CSR_PERIOD   = 3'd3,
      CSR_LEN_EN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] current_period;
      logic                channel_on;
      logic [3:0]          sample;
   } rsp_payload_type;

   // Bit n of a row is the waveform level at duty position n.
   localparam logic [7:0] DUTY_PATTERN [4] = '{
      8'b1000_0000,
      8'b1000_0001,
      8'b1110_0001,
      8'b0111_1110
   };

   function automatic logic [COUNTDOWN_W-1:0] reload_value(input logic [PERIOD_W-1:0] period);
      logic [PERIOD_W:0] span;
      span = 12'd2048 - {1'b0, period};
      reload_value = {span, 2'b00};
   endfunction

   // Bit 11 of the result set means the sum went past the 11-bit range.
   function automatic logic [PERIOD_W:0] sweep_sum(input logic [PERIOD_W-1:0] shadow,
                                                   input logic [6:0] ctrl);
      logic [PERIOD_W-1:0] offset;
      offset = shadow >> ctrl[2:0];
      if (ctrl[3]) begin
         sweep_sum = {1'b0, shadow} - {1'b0, offset};
      end else begin
         sweep_sum = {1'b0, shadow} + {1'b0, offset};
      end
   endfunction

endpackage

>>> rtl/square_channel_with_sweep.sv
// Square channel with sweep: an accepted item's result is registered in the output
// register, or the skid entry if output is held. One item per cycle while the skid
// entry is empty; this two-entry output stage keeps input ready while one result waits.
// The channel state updates in one pass of shift, add and compare. Synchronous active-high
// reset clears all channel state, registers and output valid flags. Depends on sqch_pkg.
module square_channel_with_sweep
   import sqch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] frame_index, [8:3] length_data, [15:9] zero
   input  logic [15:0]           req_tdata,
   // [1:0] op
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] sample, [4] channel_on, [15:5] current_period
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [6:0]          sweep_ctrl_ff;
   logic [1:0]          duty_sel_ff;
   logic [7:0]          env_ctrl_ff;
   logic [PERIOD_W-1:0] period_set_ff, period_set_in;
   logic                len_en_ff;

   logic                   enabled_ff, enabled_in;
   logic [PERIOD_W-1:0]    active_ff, active_in;
   logic [COUNTDOWN_W-1:0] countdown_ff, countdown_in;
   logic [2:0]             duty_pos_ff, duty_pos_in;
   logic [1:0]             duty_lat_ff, duty_lat_in;
   logic [3:0]             volume_ff, volume_in;
   logic [2:0]             env_count_ff, env_count_in;
   logic                   sweep_act_ff, sweep_act_in;
   logic [3:0]             sweep_cnt_ff, sweep_cnt_in;
   logic [PERIOD_W-1:0]    shadow_ff, shadow_in;
   logic [LENGTH_W-1:0]    length_ff, length_in;

   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_data_ff, skid_data_ff, result;

   logic          req_accept, csr_write, take;
   csr_index_type csr_index;
   op_type        op;
   logic [2:0]    frame_index;
   logic [5:0]    length_data;
   logic          dac_on;

   assign op          = op_type'(req_tuser);
   assign frame_index = req_tdata[2:0];
   assign length_data = req_tdata[8:3];
   assign req_accept  = req_tvalid && req_tready;
   assign req_tready  = !skid_valid_ff;
   assign csr_pready  = 1'b1;
   assign csr_index   = csr_index_type'(csr_paddr[4:2]);
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dac_on      = env_ctrl_ff[7:3] != 5'd0;
   assign take        = out_valid_ff && rsp_tready;

   always_comb begin
      logic [2:0]          pace;
      logic [2:0]          shift;
      logic [2:0]          epace;
      logic [PERIOD_W:0]   nx;
      logic [PERIOD_W:0]   nx2;
      logic [COUNTDOWN_W-1:0] dec;
      pace  = sweep_ctrl_ff[6:4];
      shift = sweep_ctrl_ff[2:0];
      epace = env_ctrl_ff[2:0];
      nx    = '0;
      nx2   = '0;
      dec   = countdown_ff - 14'd1;
      enabled_in    = enabled_ff;
      active_in     = active_ff;
      countdown_in  = countdown_ff;
      duty_pos_in   = duty_pos_ff;
      duty_lat_in   = duty_lat_ff;
      volume_in     = volume_ff;
      env_count_in  = env_count_ff;
      sweep_act_in  = sweep_act_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      shadow_in     = shadow_ff;
      length_in     = length_ff;
      period_set_in = period_set_ff;
      case (op)
         OP_TICK: begin
            if (enabled_ff && dac_on) begin
               countdown_in = dec;
               if (dec == '0) begin
                  active_in    = period_set_ff;
                  countdown_in = reload_value(period_set_ff);
                  duty_pos_in  = duty_pos_ff + 3'd1;
               end
            end
         end
         OP_FRAME: begin
            if (!frame_index[0] && len_en_ff && length_ff != '0) begin
               length_in = length_ff - 7'd1;
               if (length_in == '0) begin
                  enabled_in = 1'b0;
               end
            end
            if (enabled_in && (frame_index == 3'd2 || frame_index == 3'd6)) begin
               if (sweep_cnt_ff != 4'd0) begin
                  sweep_cnt_in = sweep_cnt_ff - 4'd1;
               end
               if (sweep_cnt_in == 4'd0) begin
                  sweep_cnt_in = (pace != 3'd0) ? {1'b0, pace} : SWEEP_RELOAD;
                  if (sweep_act_ff && pace != 3'd0) begin
                     nx = sweep_sum(shadow_ff, sweep_ctrl_ff);
                     if (nx[PERIOD_W]) begin
                        enabled_in = 1'b0;
                     end else if (shift != 3'd0) begin
                        shadow_in     = nx[PERIOD_W-1:0];
                        active_in     = nx[PERIOD_W-1:0];
                        period_set_in = nx[PERIOD_W-1:0];
                        nx2 = sweep_sum(nx[PERIOD_W-1:0], sweep_ctrl_ff);
                        if (nx2[PERIOD_W]) begin
                           enabled_in = 1'b0;
                        end
                     end
                  end
               end
            end
            if (enabled_in && frame_index == 3'd7 && epace != 3'd0) begin
               env_count_in = env_count_ff + 3'd1;
               if (env_count_in >= epace) begin
                  env_count_in = 3'd0;
                  if (env_ctrl_ff[3] && volume_ff != 4'hF) begin
                     volume_in = volume_ff + 4'd1;
                  end else if (!env_ctrl_ff[3] && volume_ff != 4'd0) begin
                     volume_in = volume_ff - 4'd1;
                  end
               end
            end
         end
         OP_TRIGGER: begin
            enabled_in   = dac_on;
            active_in    = period_set_ff;
            volume_in    = env_ctrl_ff[7:4];
            duty_lat_in  = duty_sel_ff;
            duty_pos_in  = 3'd0;
            countdown_in = reload_value(period_set_ff);
            if (length_ff == '0) begin
               length_in = LENGTH_FULL;
            end
            env_count_in = 3'd0;
            shadow_in    = period_set_ff;
            sweep_cnt_in = (pace != 3'd0) ? {1'b0, pace} : SWEEP_RELOAD;
            sweep_act_in = (pace != 3'd0) || (shift != 3'd0);
            if (shift != 3'd0) begin
               nx = sweep_sum(period_set_ff, sweep_ctrl_ff);
               if (nx[PERIOD_W]) begin
                  enabled_in = 1'b0;
               end
            end
         end
         OP_LENGTH: begin
            length_in = LENGTH_FULL - {1'b0, length_data};
         end
         default: begin
            length_in = length_ff;
         end
      endcase
      result.sample = (enabled_in && dac_on && DUTY_PATTERN[duty_lat_in][duty_pos_in])
                      ? volume_in : 4'd0;
      result.channel_on     = enabled_in;
      result.current_period = active_in;
   end

   always_comb begin
      case (csr_index)
         CSR_SWEEP:    csr_prdata = {25'd0, sweep_ctrl_ff};
         CSR_DUTY:     csr_prdata = {30'd0, duty_sel_ff};
         CSR_ENVELOPE: csr_prdata = {24'd0, env_ctrl_ff};
         CSR_PERIOD:   csr_prdata = {21'd0, period_set_ff};
         CSR_LEN_EN:   csr_prdata = {31'd0, len_en_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ctrl_ff <= '0;
         duty_sel_ff   <= '0;
         env_ctrl_ff   <= '0;
         period_set_ff <= '0;
         len_en_ff     <= 1'b0;
         enabled_ff    <= 1'b0;
         active_ff     <= '0;
         countdown_ff  <= '0;
         duty_pos_ff   <= '0;
         duty_lat_ff   <= '0;
         volume_ff     <= '0;
         env_count_ff  <= '0;
         sweep_act_ff  <= 1'b0;
         sweep_cnt_ff  <= '0;
         shadow_ff     <= '0;
         length_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            enabled_ff    <= enabled_in;
            active_ff     <= active_in;
            countdown_ff  <= countdown_in;
            duty_pos_ff   <= duty_pos_in;
            duty_lat_ff   <= duty_lat_in;
            volume_ff     <= volume_in;
            env_count_ff  <= env_count_in;
            sweep_act_ff  <= sweep_act_in;
            sweep_cnt_ff  <= sweep_cnt_in;
            shadow_ff     <= shadow_in;
            length_ff     <= length_in;
         end
         if (csr_write && csr_index == CSR_PERIOD) begin
            period_set_ff <= csr_pwdata[PERIOD_W-1:0];
         end else if (req_accept) begin
            period_set_ff <= period_set_in;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_SWEEP:    sweep_ctrl_ff <= csr_pwdata[6:0];
               CSR_DUTY:     duty_sel_ff   <= csr_pwdata[1:0];
               CSR_ENVELOPE: env_ctrl_ff   <= csr_pwdata[7:0];
               CSR_LEN_EN:   len_en_ff     <= csr_pwdata[0];
               default:      len_en_ff     <= len_en_ff;
            endcase
         end
         if (take || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= req_accept;
            end else begin
               out_valid_ff <= req_accept;
            end
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff  <= skid_data_ff;
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end else if (req_accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register is empty");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_off_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[4]) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("disabled channel produced a nonzero sample");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!enabled_ff && !out_valid_ff && !skid_valid_ff))
      else $error("reset did not clear channel control state");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for square_channel_with_sweep: drives tick, frame-step, trigger
// and length-load items and checks every output item against a channel model of its own.
// Depends on sqch_pkg and the block's RTL; needs no files or arguments.
module testbench;
   import sqch_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 100;
   localparam int ITEMS_PER_PHASE = 200;
   localparam logic [2:0] CSR_PAST_END   = 3'd7;
   localparam logic [2:0] FRAME_SWEEP_LO = 3'd2;
   localparam logic [2:0] FRAME_SWEEP_HI = 3'd6;
   localparam logic [2:0] FRAME_ENVELOPE = 3'd7;
   localparam logic [31:0] DUTY_WAVES = {8'b0111_1110, 8'b1110_0001, 8'b1000_0001, 8'b1000_0000};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [2:0] frame_index, [8:3] length_data, [15:9] zero
   logic [15:0] req_tdata = '0;
   // [1:0] op
   logic [1:0] req_tuser = OP_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [3:0] sample, [4] channel_on, [15:5] current_period
   logic [15:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int req_idle_pct = 28;
   int rsp_stall_pct = 60;
   int mismatch_count = 0;
   int stall_cycles = 0;
   rsp_payload_type pending_outputs[$];

   logic [6:0]            cfg_sweep = '0;
   logic [1:0]            cfg_duty = '0;
   logic [7:0]            cfg_envelope = '0;
   logic [PERIOD_W-1:0]   cfg_period = '0;
   logic                  cfg_len_en = 1'b0;

   logic                  ch_enabled = 1'b0;
   logic [PERIOD_W-1:0]   ch_period = '0;
   logic [COUNTDOWN_W-1:0] ch_countdown = '0;
   logic [2:0]            ch_duty_pos = '0;
   logic [1:0]            ch_duty_sel = '0;
   logic [3:0]            ch_volume = '0;
   logic [2:0]            ch_env_count = '0;
   logic                  ch_sweep_armed = 1'b0;
   logic [3:0]            ch_sweep_count = '0;
   logic [PERIOD_W-1:0]   ch_shadow = '0;
   logic [LENGTH_W-1:0]   ch_length = '0;

   always #2 clock = ~clock;

   square_channel_with_sweep u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic logic dac_on();
      return cfg_envelope[7:3] != 0;
   endfunction

   function automatic logic [COUNTDOWN_W-1:0] countdown_for(input logic [PERIOD_W-1:0] period);
      int unsigned span;
      span = (32'd2048 - period) * 32'd4;
      return span[COUNTDOWN_W-1:0];
   endfunction

   // Bit 11 of the returned value flags an overflow, which also turns the channel off.
   function automatic logic [PERIOD_W:0] swept_period();
      logic [PERIOD_W-1:0] offset;
      logic [PERIOD_W:0]   next_period;
      offset = ch_shadow >> cfg_sweep[2:0];
      if (cfg_sweep[3]) begin
         next_period = {1'b0, ch_shadow} - {1'b0, offset};
      end else begin
         next_period = {1'b0, ch_shadow} + {1'b0, offset};
      end
      if (next_period[PERIOD_W]) begin
         ch_enabled = 1'b0;
      end
      return next_period;
   endfunction

   function automatic void apply_register(input logic [2:0] index, input logic [31:0] value);
      case (index)
         CSR_SWEEP:    cfg_sweep = value[6:0];
         CSR_DUTY:     cfg_duty = value[1:0];
         CSR_ENVELOPE: cfg_envelope = value[7:0];
         CSR_PERIOD:   cfg_period = value[PERIOD_W-1:0];
         CSR_LEN_EN:   cfg_len_en = value[0];
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type predict_output(input op_type op, input logic [2:0] frame,
                                                      input logic [5:0] len);
      rsp_payload_type res;
      logic [PERIOD_W:0] next_period;
      logic [2:0] pace;
      logic [2:0] shift;
      pace = cfg_sweep[6:4];
      shift = cfg_sweep[2:0];
      case (op)
         OP_TICK: begin
            if (ch_enabled && dac_on()) begin
               ch_countdown = ch_countdown - 1'b1;
               if (ch_countdown == 0) begin
                  ch_period = cfg_period;
                  ch_countdown = countdown_for(ch_period);
                  ch_duty_pos = ch_duty_pos + 1'b1;
               end
            end
         end
         OP_FRAME: begin
            if (!frame[0] && cfg_len_en && ch_length != 0) begin
               ch_length = ch_length - 1'b1;
               if (ch_length == 0) begin
                  ch_enabled = 1'b0;
               end
            end
            if (ch_enabled && (frame == FRAME_SWEEP_LO || frame == FRAME_SWEEP_HI)) begin
               if (ch_sweep_count != 0) begin
                  ch_sweep_count = ch_sweep_count - 1'b1;
               end
               if (ch_sweep_count == 0) begin
                  ch_sweep_count = (pace != 0) ? {1'b0, pace} : SWEEP_RELOAD;
                  if (ch_sweep_armed && pace != 0) begin
                     next_period = swept_period();
                     if (!next_period[PERIOD_W] && shift != 0) begin
                        ch_shadow = next_period[PERIOD_W-1:0];
                        ch_period = next_period[PERIOD_W-1:0];
                        cfg_period = next_period[PERIOD_W-1:0];
                        next_period = swept_period();
                     end
                  end
               end
            end
            if (ch_enabled && frame == FRAME_ENVELOPE && cfg_envelope[2:0] != 0) begin
               ch_env_count = ch_env_count + 1'b1;
               if (ch_env_count >= cfg_envelope[2:0]) begin
                  ch_env_count = '0;
                  if (cfg_envelope[3] && ch_volume != 4'hF) begin
                     ch_volume = ch_volume + 1'b1;
                  end else if (!cfg_envelope[3] && ch_volume != 0) begin
                     ch_volume = ch_volume - 1'b1;
                  end
               end
            end
         end
         OP_TRIGGER: begin
            ch_enabled = dac_on();
            ch_period = cfg_period;
            ch_volume = cfg_envelope[7:4];
            ch_duty_sel = cfg_duty;
            ch_duty_pos = '0;
            ch_countdown = countdown_for(ch_period);
            if (ch_length == 0) begin
               ch_length = LENGTH_FULL;
            end
            ch_env_count = '0;
            ch_shadow = ch_period;
            ch_sweep_count = (pace != 0) ? {1'b0, pace} : SWEEP_RELOAD;
            ch_sweep_armed = (pace != 0) || (shift != 0);
            if (shift != 0) begin
               next_period = swept_period();
            end
         end
         OP_LENGTH: begin
            ch_length = LENGTH_FULL - len;
         end
         default: ;
      endcase
      res.sample = (ch_enabled && dac_on() && DUTY_WAVES[{ch_duty_sel, ch_duty_pos}]) ?
                   ch_volume : 4'd0;
      res.channel_on = ch_enabled;
      res.current_period = ch_period;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input int unsigned want,
                                         input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_outputs
      rsp_payload_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: output item %h arrived with nothing expected", $time, rsp_tdata);
            end
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata[3:0] !== want.sample) begin
               note_mismatch("sample", want.sample, rsp_tdata[3:0]);
            end
            if (rsp_tdata[4] !== want.channel_on) begin
               note_mismatch("channel_on", want.channel_on, rsp_tdata[4]);
            end
            if (rsp_tdata[15:5] !== want.current_period) begin
               note_mismatch("current_period", want.current_period, rsp_tdata[15:5]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_item(input op_type op, input logic [2:0] frame, input logic [5:0] len);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, len, frame};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_outputs.push_back(predict_output(op, frame, len));
   endtask

   task automatic drain_outputs();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      drain_outputs();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      apply_register(index, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic randomize_registers();
      logic [31:0] sweep;
      logic [31:0] envelope;
      logic [31:0] period;
      sweep = ($urandom_range(0, 3) << 4) | ($urandom_range(0, 1) << 3) | $urandom_range(0, 7);
      if ($urandom_range(0, 7) == 0) begin
         sweep = $urandom_range(0, 1) ? 32'h7F : 32'h00;
      end
      envelope = $urandom_range(0, 255);
      if ($urandom_range(0, 7) == 0) begin
         envelope = $urandom_range(0, 1) ? 32'hFF : 32'h00;
      end
      case ($urandom_range(0, 9))
         0: period = 32'd0;
         1: period = 32'd2047;
         2, 3, 4: period = $urandom_range(0, 2047);
         default: period = $urandom_range(2032, 2047);
      endcase
      csr_write(CSR_SWEEP, sweep);
      csr_write(CSR_DUTY, $urandom_range(0, 3));
      csr_write(CSR_ENVELOPE, envelope);
      csr_write(CSR_PERIOD, period);
      csr_write(CSR_LEN_EN, $urandom_range(0, 1));
   endtask

   task automatic test_directed_cases();
      send_item(OP_TICK, 3'd0, 6'd0);
      send_item(OP_FRAME, 3'd0, 6'd63);
      csr_write(CSR_ENVELOPE, 32'h07);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      csr_write(CSR_ENVELOPE, 32'hF0);
      csr_write(CSR_DUTY, 32'd3);
      csr_write(CSR_PERIOD, 32'd2047);
      csr_write(CSR_LEN_EN, 32'd1);
      csr_write(CSR_SWEEP, 32'h00);
      send_item(OP_LENGTH, 3'd0, 6'd63);
      send_item(OP_TRIGGER, 3'd7, 6'd0);
      repeat (4) send_item(OP_TICK, 3'd0, 6'd0);
      send_item(OP_FRAME, FRAME_ENVELOPE, 6'd0);
      // The length counter runs out on a sweep step, so the sweep must not run.
      send_item(OP_FRAME, FRAME_SWEEP_LO, 6'd0);
      send_item(OP_FRAME, FRAME_SWEEP_HI, 6'd0);
      csr_write(CSR_SWEEP, 32'h11);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      csr_write(CSR_PERIOD, 32'd1000);
      csr_write(CSR_SWEEP, 32'h10);
      send_item(OP_LENGTH, 3'd0, 6'd0);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      send_item(OP_FRAME, FRAME_SWEEP_LO, 6'd0);
      csr_write(CSR_SWEEP, 32'h19);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      send_item(OP_FRAME, FRAME_SWEEP_LO, 6'd0);
      send_item(OP_FRAME, FRAME_SWEEP_HI, 6'd0);
      csr_write(CSR_ENVELOPE, 32'hF9);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      send_item(OP_FRAME, FRAME_ENVELOPE, 6'd0);
      csr_write(CSR_SWEEP, 32'h7F);
      csr_write(CSR_PERIOD, 32'd0);
      send_item(OP_TRIGGER, 3'd5, 6'd42);
      send_item(OP_TICK, 3'd7, 6'd63);
   endtask

   task automatic test_unmapped_register();
      csr_write(CSR_PAST_END, 32'hFFFF_FFFF);
      send_item(OP_TRIGGER, 3'd0, 6'd0);
      send_item(OP_TICK, 3'd0, 6'd0);
   endtask

   task automatic test_random_sequences(input int unsigned count);
      int unsigned sent;
      logic [2:0] seq_step;
      sent = 0;
      while (sent < count) begin
         randomize_registers();
         seq_step = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 7) begin
            send_item(OP_LENGTH, 3'($urandom_range(0, 7)),
                      6'(($urandom_range(0, 9) < 3) ? $urandom_range(56, 63)
                                                    : $urandom_range(0, 63)));
            sent++;
         end
         send_item(OP_TRIGGER, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
         sent++;
         repeat ($urandom_range(20, 50)) begin
            if ($urandom_range(0, 99) < 85) begin
               if ($urandom_range(0, 3) != 0) begin
                  send_item(OP_TICK, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
               end else begin
                  send_item(OP_FRAME, seq_step, 6'($urandom_range(0, 63)));
                  seq_step = seq_step + 1'b1;
               end
            end else begin
               send_item(op_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         6'($urandom_range(0, 63)));
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 28;
      rsp_stall_pct = 60;
      test_directed_cases();
      test_unmapped_register();
      test_random_sequences(ITEMS_PER_PHASE);
      req_idle_pct = 60;
      rsp_stall_pct = 28;
      test_random_sequences(ITEMS_PER_PHASE);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_sequences(ITEMS_PER_PHASE);
      drain_outputs();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
